### rtl/pair_key_sorter_core_assert.svh
// Assertion macros used by the sorter's port checker file.
`ifndef PAIR_KEY_SORTER_CORE_ASSERT_SVH
`define PAIR_KEY_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define PKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define PKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pks_pkg.sv
// Types, operation codes and key ordering shared by the pair sorter.
package pks_pkg;

  // Default capacity of the sorting chain
  localparam int MAX_PAIRS_DEF = 64;

  // Cell operation codes
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;
  localparam logic [1:0] OP_EMIT = 2'd3;

  typedef struct packed {
    logic signed [31:0] primary;
    logic signed [31:0] secondary;
  } pair_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic [1:0] op;
    logic       phase;  // which neighbour pairing is active in a sort round
  } ctrl_t;

  // Unsigned key whose ordering matches the selected pair order
  function automatic logic [63:0] sort_key(pair_t p, logic desc);
    logic [31:0] pk;
    logic [31:0] sk;
    pk = $unsigned(p.primary) ^ 32'h8000_0000;
    sk = $unsigned(p.secondary) ^ 32'h8000_0000;
    if (desc) begin
      sk = ~sk;
    end
    return {pk, sk};
  endfunction

endpackage

### rtl/pair_key_sorter_core.sv
// Top level of the pair sorter: chain of cells, run control and stream ports.
// Pairs arrive one per cycle and shift into a chain of MAX_PAIRS cells;
// pairs beyond capacity are dropped and the run's results then carry tuser
// (overflow) high. The pair with tlast ends the run: the chain then runs n
// rounds of odd-even transposition (n = pairs held, one compare per cell
// pair per round) and shifts the sorted run out of cell 0, one result per
// cycle while m_tready is high, tlast on the final one. Input is not taken
// during the sort and output phases. Order is primary key ascending, ties
// by secondary key descending (cfg_wdata = 1, reset value) or ascending (0).
module pair_key_sorter_core #(
  parameter int MAX_PAIRS = pks_pkg::MAX_PAIRS_DEF  // 2 to 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // secondary_descending
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,     // [31:0] primary_key, [63:32] secondary_key
  input  logic        s_tlast,     // last_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // [31:0] sorted_primary, [63:32] sorted_secondary
  output logic        m_tlast,     // last_out
  output logic        m_tuser      // overflow
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rounds;
  logic [CNT_W-1:0] rounds_next;
  logic             dropped;
  logic             dropped_next;
  logic             desc;

  logic             s_acc;
  logic             m_acc;
  logic             has_room;
  pks_pkg::ctrl_t   ctrl;
  pks_pkg::pair_t   in_pair;

  pks_pkg::pair_t   cell_pair  [MAX_PAIRS];
  logic             cell_valid [MAX_PAIRS];
  logic             cell_gt    [MAX_PAIRS];

  // Stream handshakes
  assign s_tready = (state == ST_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_EMIT) && cell_valid[0];
  assign m_acc    = m_tvalid && m_tready;
  assign has_room = (count < CNT_W'(MAX_PAIRS));

  assign in_pair.primary   = $signed(s_tdata[31:0]);
  assign in_pair.secondary = $signed(s_tdata[63:32]);

  // Result from the bottom of the chain
  assign m_tdata = {$unsigned(cell_pair[0].secondary), $unsigned(cell_pair[0].primary)};
  assign m_tlast = !cell_valid[1];
  assign m_tuser = dropped;

  // Chain control
  always_comb begin
    ctrl.phase = rounds[0];
    if (s_acc && has_room) begin
      ctrl.op = pks_pkg::OP_LOAD;
    end else if (state == ST_SORT) begin
      ctrl.op = pks_pkg::OP_SORT;
    end else if (m_acc) begin
      ctrl.op = pks_pkg::OP_EMIT;
    end else begin
      ctrl.op = pks_pkg::OP_HOLD;
    end
  end

  // Run sequencing
  always_comb begin
    state_next   = state;
    count_next   = count;
    rounds_next  = rounds;
    dropped_next = dropped;
    unique case (state)
      ST_LOAD: begin
        if (s_acc) begin
          if (has_room) begin
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (s_tlast) begin
            rounds_next = count_next;
            state_next  = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        rounds_next = rounds - CNT_W'(1);
        if (rounds <= CNT_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_acc && m_tlast) begin
          count_next   = '0;
          dropped_next = 1'b0;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      rounds  <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rounds  <= rounds_next;
      dropped <= dropped_next;
    end
  end

  // Tie-break mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      desc <= 1'b1;
    end else if (cfg_we) begin
      desc <= cfg_wdata;
    end
  end

  // Cell chain: cell 0 takes new pairs and gives results
  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    pks_pkg::pair_t lo_pair;
    logic           lo_valid;
    logic           lo_gt;
    pks_pkg::pair_t up_pair;
    logic           up_valid;

    if (i == 0) begin : g_bottom
      assign lo_pair  = in_pair;
      assign lo_valid = 1'b1;
      assign lo_gt    = 1'b0;
    end else begin : g_mid_lo
      assign lo_pair  = cell_pair[i-1];
      assign lo_valid = cell_valid[i-1];
      assign lo_gt    = cell_gt[i-1];
    end

    if (i == MAX_PAIRS - 1) begin : g_top
      assign up_pair  = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid_up
      assign up_pair  = cell_pair[i+1];
      assign up_valid = cell_valid[i+1];
    end

    pks_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .odd_pos     (1'(i % 2)),
      .desc        (desc),
      .lower_pair  (lo_pair),
      .lower_valid (lo_valid),
      .lower_gt    (lo_gt),
      .upper_pair  (up_pair),
      .upper_valid (up_valid),
      .pair        (cell_pair[i]),
      .valid       (cell_valid[i]),
      .gt_up       (cell_gt[i])
    );
  end

endmodule

### rtl/pks_cell.sv
// One cell of the sorting chain: holds a pair and swaps with its neighbours.
module pks_cell (
  input  logic            clk,
  input  logic            rst,
  input  pks_pkg::ctrl_t  ctrl,
  input  logic            odd_pos,      // position parity of this cell
  input  logic            desc,         // secondary ties broken descending
  input  pks_pkg::pair_t  lower_pair,
  input  logic            lower_valid,
  input  logic            lower_gt,     // lower cell holds a greater key than this one
  input  pks_pkg::pair_t  upper_pair,
  input  logic            upper_valid,
  output pks_pkg::pair_t  pair,
  output logic            valid,
  output logic            gt_up         // this cell's key is greater than the upper one
);

  pks_pkg::pair_t pair_next;
  logic           valid_next;
  logic           own_turn;

  // Compare with the upper neighbour; empty cells sit above all keys
  assign gt_up = valid && upper_valid &&
                 (pks_pkg::sort_key(pair, desc) > pks_pkg::sort_key(upper_pair, desc));

  // In a sort round this cell pairs upwards when its parity matches the phase
  assign own_turn = (odd_pos == ctrl.phase);

  always_comb begin
    pair_next  = pair;
    valid_next = valid;
    unique case (ctrl.op)
      pks_pkg::OP_LOAD: begin
        pair_next  = lower_pair;
        valid_next = lower_valid;
      end
      pks_pkg::OP_SORT: begin
        if (own_turn && gt_up) begin
          pair_next  = upper_pair;
          valid_next = upper_valid;
        end else if (!own_turn && lower_gt) begin
          pair_next  = lower_pair;
          valid_next = lower_valid;
        end
      end
      pks_pkg::OP_EMIT: begin
        pair_next  = upper_pair;
        valid_next = upper_valid;
      end
      default: begin
        pair_next  = pair;
        valid_next = valid;
      end
    endcase
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pair <= pair_next;
  end

endmodule

### rtl/pks_checker.sv
// Port-level checks for the pair sorter, bound to its top level.
`include "pair_key_sorter_core_assert.svh"

module pks_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result stays offered
  `PKS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // A stalled result keeps its data
  `PKS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

  // Input is closed while a run is being delivered
  `PKS_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken during output phase")

  // Closing pair of a run starts the sort and closes the input
  `PKS_ASSERT_NEXT(a_run_close, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid,
                   "input still open after run end")

  // Final result ends the output phase
  `PKS_ASSERT_NEXT(a_out_end, m_tvalid && m_tready && m_tlast, !m_tvalid,
                   "result offered after final result")

endmodule

bind pair_key_sorter_core pks_checker u_pks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### bench/pks_sort_checker.sv
`timescale 1ns / 1ps
// Sort checker for the pair sorter: predicts each sorted run and compares every result.
module pks_sort_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,     // [31:0] primary_key, [63:32] secondary_key
  input  logic        s_tlast,     // last_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,     // [31:0] sorted_primary, [63:32] sorted_secondary
  input  logic        m_tlast,     // last_out
  input  logic        m_tuser,     // overflow
  output int          mismatches,
  output int          expected_left
);

  typedef struct packed {
    logic signed [31:0] primary;
    logic signed [31:0] secondary;
    logic               last_out;
    logic               overflow;
  } sorted_pair_t;

  pks_pkg::pair_t held_pairs[$];    // pairs of the run in progress, arrival order
  sorted_pair_t   sorted_expect[$]; // results still owed by the block
  logic           run_dropped = 1'b0;
  logic           desc_mode   = 1'b1;
  int             fail_total  = 0;

  // Strict ordering: primary ascending, then secondary as the mode selects
  function automatic bit precedes(pks_pkg::pair_t a, pks_pkg::pair_t b, logic desc);
    if ($signed(a.primary) != $signed(b.primary)) begin
      return $signed(a.primary) < $signed(b.primary);
    end
    if (desc) begin
      return $signed(a.secondary) > $signed(b.secondary);
    end
    return $signed(a.secondary) < $signed(b.secondary);
  endfunction

  // Sort the held run and queue one result per pair
  function automatic void close_run();
    pks_pkg::pair_t ordered[$];
    sorted_pair_t   res;
    int             pos;
    bit             placed;
    foreach (held_pairs[i]) begin
      placed = 1'b0;
      pos = ordered.size();
      for (int k = 0; k < ordered.size(); k++) begin
        if (!placed && precedes(held_pairs[i], ordered[k], desc_mode)) begin
          pos = k;
          placed = 1'b1;
        end
      end
      ordered.insert(pos, held_pairs[i]);
    end
    foreach (ordered[k]) begin
      res.primary   = ordered[k].primary;
      res.secondary = ordered[k].secondary;
      res.last_out  = (k == ordered.size() - 1);
      res.overflow  = run_dropped;
      sorted_expect.insert(sorted_expect.size(), res);
    end
    held_pairs.delete();
    run_dropped = 1'b0;
  endfunction

  // Watch both channels and the mode register on every edge
  always @(posedge clk) begin : watch
    sorted_pair_t   want;
    pks_pkg::pair_t incoming;
    if (rst) begin
      held_pairs.delete();
      sorted_expect.delete();
      run_dropped = 1'b0;
      desc_mode   = 1'b1;
    end else begin
      if (cfg_we) begin
        desc_mode = cfg_wdata;
      end
      // result side first, so a run closing on this edge cannot be matched early
      if (m_tvalid && m_tready) begin
        if (sorted_expect.size() == 0) begin
          $error("result with none expected: primary %0d, secondary %0d",
                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
          fail_total++;
        end else begin
          want = sorted_expect.pop_front();
          if (m_tdata[31:0] !== want.primary) begin
            $error("sorted_primary: expected %0d, got %0d",
                   want.primary, $signed(m_tdata[31:0]));
            fail_total++;
          end
          if (m_tdata[63:32] !== want.secondary) begin
            $error("sorted_secondary: expected %0d, got %0d",
                   want.secondary, $signed(m_tdata[63:32]));
            fail_total++;
          end
          if (m_tlast !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, m_tlast);
            fail_total++;
          end
          if (m_tuser !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, m_tuser);
            fail_total++;
          end
        end
      end
      // input side: store or drop, close the run on tlast
      if (s_tvalid && s_tready) begin
        if (held_pairs.size() < CAPACITY) begin
          incoming.primary   = s_tdata[31:0];
          incoming.secondary = s_tdata[63:32];
          held_pairs.insert(held_pairs.size(), incoming);
        end else begin
          run_dropped = 1'b1;
        end
        if (s_tlast) begin
          close_run();
        end
      end
    end
    mismatches    <= fail_total;
    expected_left <= sorted_expect.size();
  end

endmodule

### bench/pair_key_sorter_core_test.sv
`timescale 1ns / 1ps
// Bench top for the pair sorter: clock, reset, stimulus, result sink and verdict.
module pair_key_sorter_core_test;

  localparam int CAPACITY    = pks_pkg::MAX_PAIRS_DEF;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int mismatches;
  int expected_left;
  int cycles   = 0;
  int tx_left  = 0;
  bit tx_steady = 1'b0;

  pair_key_sorter_core #(
    .MAX_PAIRS(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  pks_sort_checker #(
    .CAPACITY(CAPACITY)
  ) sort_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .expected_left(expected_left)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Key mix: small values for ties, the extremes, and full-range noise
  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One input transaction, preceded by a random gap (none inside a steady stretch)
  task automatic send_pair(input logic signed [31:0] prim, input logic signed [31:0] sec,
                           input logic last);
    int gap;
    if (tx_left == 0) begin
      tx_left   = $urandom_range(5, 30);
      tx_steady = ($urandom_range(0, 3) == 0);
    end
    tx_left--;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sec, prim};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) begin
      send_pair(rand_key(), rand_key(), i == len - 1);
    end
  endtask

  // Hold off until every owed result is out, then let the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic desc);
    cfg_we    <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result sink with random stalls and steady stretches
  initial begin : result_sink
    int stall;
    int rx_left;
    bit rx_steady;
    m_tready  = 1'b0;
    rx_left   = 0;
    rx_steady = 1'b0;
    forever begin
      if (rx_left == 0) begin
        rx_left   = $urandom_range(5, 40);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      rx_left--;
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Stimulus
  initial begin : stimulus
    int sent;
    int big;
    int len;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b1);

    // extremes, primary ties and a duplicate pair; ties broken descending
    send_pair(KEY_MAX, KEY_MIN, 1'b0);
    send_pair(KEY_MIN, KEY_MAX, 1'b0);
    send_pair(32'sd0, -32'sd1, 1'b0);
    send_pair(32'sd0, 32'sd1, 1'b0);
    send_pair(32'sd0, 32'sd1, 1'b0);
    send_pair(-32'sd1, 32'sd0, 1'b0);
    send_pair(KEY_MIN, KEY_MIN, 1'b0);
    send_pair(KEY_MAX, KEY_MAX, 1'b1);
    // run of a single pair
    send_pair(-32'sd7, 32'sd7, 1'b1);
    wait_drained();

    // ties broken ascending
    write_mode(1'b0);
    send_pair(32'sd5, 32'sd3, 1'b0);
    send_pair(32'sd5, -32'sd3, 1'b0);
    send_pair(32'sd5, KEY_MIN, 1'b0);
    send_pair(32'sd5, KEY_MAX, 1'b0);
    send_pair(-32'sd5, 32'sd0, 1'b0);
    send_pair(KEY_MAX, KEY_MIN, 1'b0);
    send_pair(KEY_MIN, KEY_MAX, 1'b1);
    // reverse-ordered arrival
    send_pair(32'sd3, 32'sd0, 1'b0);
    send_pair(32'sd2, 32'sd0, 1'b0);
    send_pair(32'sd1, 32'sd0, 1'b0);
    send_pair(32'sd0, 32'sd0, 1'b1);

    // random phases, alternating tie order; one full run and two that overflow
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_mode(phase % 2 == 0);
      case (phase)
        0: big = CAPACITY;      // exactly full, nothing dropped
        2: big = CAPACITY + 1;  // only the pair marked last is dropped
        3: big = CAPACITY + 3;  // several dropped, last among them
        default: big = 0;
      endcase
      sent = 0;
      if (big != 0) begin
        send_run(big);
        sent = big;
      end
      while (sent < big + 18) begin
        len = $urandom_range(1, 8);
        send_run(len);
        sent += len;
      end
    end
    wait_drained();

    if (mismatches == 0 && expected_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
